// ===== src/pfb_pkg.sv =====
// Package for the page frame buffer drawing engine.
// Holds geometry constants, command and result word types, and controller/datapath structs.
// No dependencies.
package pfb_pkg;

  localparam int COLUMNS   = 128;
  localparam int PAGES     = 8;
  localparam int ROWS      = PAGES * 8;
  localparam int MEM_DEPTH = COLUMNS * PAGES;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int PAGE_W    = (PAGES > 1) ? $clog2(PAGES) : 1;

  typedef enum logic [2:0] {
    KIND_SET    = 3'd0,
    KIND_INVERT = 3'd1,
    KIND_CLEAR  = 3'd2,
    KIND_BOX    = 3'd3,
    KIND_READ   = 3'd4
  } kind_t;

  localparam logic STATUS_DONE   = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  localparam logic FILL_SET    = 1'b0;
  localparam logic FILL_INVERT = 1'b1;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] x_pos;
    logic [6:0] y_pos;
    logic [2:0] page_index;
    logic [7:0] box_width;
    logic [6:0] box_height;
    logic [5:0] corner_cut;
    logic       fill_mode;
  } cmd_word_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       status;
  } res_word_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_READ_RD,
    ST_BOX_COL,
    ST_BOX_SPAN,
    ST_BOX_RD,
    ST_BOX_WR,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic clearing;
    logic clr_step;
    logic rd_en;
    logic wr_en;
    logic col_init;
    logic col_calc;
    logic col_next;
    logic page_init;
    logic page_next;
    logic res_load;
  } ctl_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  pix_on;
    logic  rd_on;
    logic  box_reject;
    logic  box_empty;
    logic  span_empty;
    logic  page_last;
    logic  col_last;
    logic  clr_last;
    logic  res_busy;
  } dp_stat_t;

endpackage

// ===== src/pfb_ctrl.sv =====
// Controller state machine for the page frame buffer drawing engine.
// Sequences clearing, pixel read-modify-write, reads and box column/page walks.
// Depends on pfb_pkg.
module pfb_ctrl import pfb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  output logic     cmd_stall,
  input  dp_stat_t stat,
  output ctl_cmd_t ctl
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    cmd_stall  = 1'b1;
    case (state)
      ST_CLEAR: begin
        ctl.clearing = 1'b1;
        ctl.wr_en    = 1'b1;
        ctl.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd_stall = 1'b0;
        if (cmd_valid) begin
          ctl.load   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (stat.kind)
          KIND_SET, KIND_INVERT, KIND_CLEAR: begin
            state_next = stat.pix_on ? ST_PIX_RD : ST_FINISH;
          end
          KIND_BOX: begin
            if (stat.box_reject || stat.box_empty) begin
              state_next = ST_FINISH;
            end else begin
              ctl.col_init = 1'b1;
              state_next   = ST_BOX_COL;
            end
          end
          KIND_READ: begin
            state_next = stat.rd_on ? ST_READ_RD : ST_FINISH;
          end
          default: begin
            state_next = ST_FINISH;
          end
        endcase
      end
      ST_PIX_RD: begin
        ctl.rd_en  = 1'b1;
        state_next = ST_PIX_WR;
      end
      ST_PIX_WR: begin
        ctl.wr_en  = 1'b1;
        state_next = ST_FINISH;
      end
      ST_READ_RD: begin
        ctl.rd_en  = 1'b1;
        state_next = ST_FINISH;
      end
      ST_BOX_COL: begin
        ctl.col_calc = 1'b1;
        state_next   = ST_BOX_SPAN;
      end
      ST_BOX_SPAN: begin
        if (stat.span_empty) begin
          if (stat.col_last) begin
            state_next = ST_FINISH;
          end else begin
            ctl.col_next = 1'b1;
            state_next   = ST_BOX_COL;
          end
        end else begin
          ctl.page_init = 1'b1;
          state_next    = ST_BOX_RD;
        end
      end
      ST_BOX_RD: begin
        ctl.rd_en  = 1'b1;
        state_next = ST_BOX_WR;
      end
      ST_BOX_WR: begin
        ctl.wr_en = 1'b1;
        if (stat.page_last) begin
          if (stat.col_last) begin
            state_next = ST_FINISH;
          end else begin
            ctl.col_next = 1'b1;
            state_next   = ST_BOX_COL;
          end
        end else begin
          ctl.page_next = 1'b1;
          state_next    = ST_BOX_RD;
        end
      end
      ST_FINISH: begin
        if (!stat.res_busy) begin
          ctl.res_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== src/pfb_dpath.sv =====
// Datapath for the page frame buffer drawing engine.
// Holds the frame store, the command word, box column/page walkers and the result register.
// Depends on pfb_pkg.
module pfb_dpath import pfb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cmd_word_t cmd,
  input  ctl_cmd_t  ctl,
  input  logic      res_stall,
  output logic      res_valid,
  output res_word_t res,
  output dp_stat_t  stat
);

  logic [7:0]        mem [MEM_DEPTH];
  cmd_word_t         item;
  logic [7:0]        col;
  logic [PAGE_W-1:0] pg;
  logic [7:0]        off;
  logic [6:0]        rlo;
  logic [6:0]        rhi;
  logic              span_empty;
  logic [ADDR_W-1:0] clr_addr;
  logic [7:0]        rdata;

  logic [15:0]       addr_full;
  logic [ADDR_W-1:0] mem_addr;
  logic [7:0]        wdata;
  logic [7:0]        modified;
  logic [7:0]        mask;
  logic [7:0]        pix_mask;
  logic [7:0]        box_mask;
  logic [6:0]        rlo_page;
  logic [6:0]        rhi_page;
  logic [2:0]        lo_bit;
  logic [2:0]        hi_bit;

  logic [7:0]        wm1;
  logic [7:0]        rest;
  logic [7:0]        col_dist;
  logic [7:0]        cut8;
  logic [7:0]        inset;
  logic [6:0]        top;
  logic [6:0]        rlo_next;
  logic [6:0]        rhi_next;
  logic              empty_next;

  logic [9:0]        x_end;
  logic [7:0]        cut2;
  logic              reject;
  logic              pix_on;
  logic              rd_on;

  // Frame store: one byte per column and page, read data registered.
  assign addr_full = 16'(col) * 16'(PAGES) + 16'(pg);
  assign mem_addr  = ctl.clearing ? clr_addr : addr_full[ADDR_W-1:0];
  assign wdata     = ctl.clearing ? 8'd0 : modified;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[mem_addr] <= wdata;
    end
    if (ctl.rd_en) begin
      rdata <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (ctl.clr_step) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  // Command checks.
  assign x_end  = 10'(item.x_pos) + 10'(item.box_width);
  assign cut2   = 8'({item.corner_cut, 1'b0});
  assign reject = (item.x_pos == 8'd0) || (x_end > 10'(COLUMNS + 1)) ||
                  (8'(item.y_pos) > 8'(ROWS)) || (item.y_pos < item.box_height) ||
                  (cut2 > item.box_width) || (cut2 > 8'(item.box_height));
  assign pix_on = (9'(item.x_pos) < 9'(COLUMNS)) && (8'(item.y_pos) < 8'(ROWS));
  assign rd_on  = (9'(item.x_pos) < 9'(COLUMNS)) && (5'(item.page_index) < 5'(PAGES));

  // Vertical span of the current box column.
  assign wm1        = item.box_width - 8'd1;
  assign rest       = wm1 - off;
  assign col_dist   = (off < rest) ? off : rest;
  assign cut8       = 8'(item.corner_cut);
  assign inset      = (cut8 > col_dist) ? (cut8 - col_dist) : 8'd0;
  assign top        = item.y_pos - item.box_height;
  assign rlo_next   = top + inset[6:0];
  assign rhi_next   = item.y_pos - 7'd1 - inset[6:0];
  assign empty_next = (8'(item.box_height) <= {inset[6:0], 1'b0});

  assign rlo_page = rlo >> 3;
  assign rhi_page = rhi >> 3;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item <= cmd;
      col  <= cmd.x_pos;
    end else if (ctl.col_init) begin
      col <= item.x_pos - 8'd1;
    end else if (ctl.col_next) begin
      col <= col + 8'd1;
    end
    if (ctl.col_init) begin
      off <= 8'd0;
    end else if (ctl.col_next) begin
      off <= off + 8'd1;
    end
    if (ctl.col_calc) begin
      rlo        <= rlo_next;
      rhi        <= rhi_next;
      span_empty <= empty_next;
    end
    if (ctl.load) begin
      pg <= (cmd.kind == KIND_READ) ? PAGE_W'(cmd.page_index) : PAGE_W'(cmd.y_pos >> 3);
    end else if (ctl.page_init) begin
      pg <= rlo_page[PAGE_W-1:0];
    end else if (ctl.page_next) begin
      pg <= pg + PAGE_W'(1);
    end
  end

  // Byte modification.
  assign pix_mask = 8'd1 << item.y_pos[2:0];
  assign lo_bit   = (pg == rlo_page[PAGE_W-1:0]) ? rlo[2:0] : 3'd0;
  assign hi_bit   = (pg == rhi_page[PAGE_W-1:0]) ? rhi[2:0] : 3'd7;
  assign box_mask = (8'hFF << lo_bit) & (8'hFF >> (3'd7 - hi_bit));
  assign mask     = (item.kind == KIND_BOX) ? box_mask : pix_mask;

  always_comb begin
    case (item.kind)
      KIND_SET:    modified = rdata | mask;
      KIND_INVERT: modified = rdata ^ mask;
      KIND_CLEAR:  modified = rdata & ~mask;
      KIND_BOX:    modified = (item.fill_mode == FILL_INVERT) ? (rdata ^ mask) : (rdata | mask);
      default:     modified = rdata;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.res_load) begin
      res.read_byte <= ((item.kind == KIND_READ) && rd_on) ? rdata : 8'd0;
      res.status    <= ((item.kind == KIND_BOX) && reject) ? STATUS_REJECT : STATUS_DONE;
    end
  end

  assign stat.kind       = kind_t'(item.kind);
  assign stat.pix_on     = pix_on;
  assign stat.rd_on      = rd_on;
  assign stat.box_reject = reject;
  assign stat.box_empty  = (item.box_width == 8'd0) || (item.box_height == 7'd0);
  assign stat.span_empty = span_empty;
  assign stat.page_last  = (pg == rhi_page[PAGE_W-1:0]);
  assign stat.col_last   = (off == wm1);
  assign stat.clr_last   = (clr_addr == ADDR_W'(MEM_DEPTH - 1));
  assign stat.res_busy   = res_valid && res_stall;

endmodule

// ===== src/page_framebuffer_box_and_pixel_engine.sv =====
// Top level of the page frame buffer drawing engine.
// Joins the controller and the datapath; depends on pfb_pkg, pfb_ctrl and pfb_dpath.
//
// The engine keeps a 128 x 64 monochrome picture as page bytes and takes one command word at a
// time. After reset it clears all 1024 bytes of the frame store, one byte per cycle, during
// which no command is accepted. A pixel command steps through decode, read, write and result,
// a read through decode, read and result, and a rejected, empty, out-of-range or unused command
// through decode and result. A box fill walks its columns one at a time through the single
// frame store port: a span calculation per column, then a read followed by a write for each
// page byte that the column touches. The result word is registered, so a new command is
// accepted while the previous result still waits to be taken.
module page_framebuffer_box_and_pixel_engine import pfb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  input  cmd_word_t cmd,
  output logic      res_valid,
  input  logic      res_stall,
  output res_word_t res
);

  ctl_cmd_t ctl;
  dp_stat_t stat;

  pfb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  pfb_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .ctl       (ctl),
    .res_stall (res_stall),
    .res_valid (res_valid),
    .res       (res),
    .stat      (stat)
  );

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    ctl.clearing |-> cmd_stall)
    else $error("Command word accepted during the clearing pass.");

  a_result_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(ctl.res_load))
    else $error("Result became valid without a load.");

  a_single_port: assert property (@(posedge clk) disable iff (rst)
    ctl.rd_en |-> !ctl.wr_en)
    else $error("Frame store read and written in the same cycle.");

  a_reject_no_byte: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.status == STATUS_REJECT)) |-> (res.read_byte == 8'd0))
    else $error("Rejected box reports a non-zero byte.");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the page frame buffer drawing engine.
// Mirrors the frame store to predict every result word; depends on pfb_pkg and the top level.
module testbench;
  import pfb_pkg::*;

  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;
  localparam int RANDOM_WORDS = 950;
  localparam int SHOWN_MAX = 10;

  class frame_mirror;
    logic [7:0] shadow [MEM_DEPTH];
    res_word_t due [$];
    int errors;
    int pixel_cmds;
    int box_cmds;
    int box_refused;
    int read_cmds;
    int read_lit;

    function new();
      foreach (shadow[i]) shadow[i] = 8'h00;
      errors = 0;
      pixel_cmds = 0;
      box_cmds = 0;
      box_refused = 0;
      read_cmds = 0;
      read_lit = 0;
    endfunction

    function void complain(string what);
      errors++;
      if (errors <= SHOWN_MAX) $display("%0t: %s", $realtime, what);
    endfunction

    function void touch(int col, int row, logic [2:0] op);
      int idx;
      if (col < 0 || col >= COLUMNS || row < 0 || row >= ROWS) return;
      idx = col * PAGES + row / 8;
      case (op)
        KIND_SET: shadow[idx][row % 8] = 1'b1;
        KIND_INVERT: shadow[idx][row % 8] = ~shadow[idx][row % 8];
        default: shadow[idx][row % 8] = 1'b0;
      endcase
    endfunction

    function bit paint_box(cmd_word_t w);
      int x, y, bw, bh, cut, left, top, d, inset;
      logic [2:0] op;
      x = int'(w.x_pos);
      y = int'(w.y_pos);
      bw = int'(w.box_width);
      bh = int'(w.box_height);
      cut = int'(w.corner_cut);
      if (x < 1 || x + bw - 1 > COLUMNS || y > ROWS || y < bh || 2 * cut > bw || 2 * cut > bh)
        return 1'b1;
      op = (w.fill_mode == FILL_INVERT) ? KIND_INVERT : KIND_SET;
      left = x - 1;
      top = y - bh;
      for (int k = 0; k < bh; k++) begin
        d = (k < bh - 1 - k) ? k : bh - 1 - k;
        inset = (d < cut) ? cut - d : 0;
        for (int c = left + inset; c <= left + bw - 1 - inset; c++) touch(c, top + k, op);
      end
      return 1'b0;
    endfunction

    function void take_command(cmd_word_t w);
      res_word_t r;
      r.read_byte = 8'h00;
      r.status = STATUS_DONE;
      case (w.kind)
        KIND_SET, KIND_INVERT, KIND_CLEAR: begin
          pixel_cmds++;
          touch(int'(w.x_pos), int'(w.y_pos), w.kind);
        end
        KIND_BOX: begin
          box_cmds++;
          if (paint_box(w)) begin
            r.status = STATUS_REJECT;
            box_refused++;
          end
        end
        KIND_READ: begin
          read_cmds++;
          if (int'(w.x_pos) < COLUMNS && int'(w.page_index) < PAGES)
            r.read_byte = shadow[int'(w.x_pos) * PAGES + int'(w.page_index)];
          if (r.read_byte != 8'h00) read_lit++;
        end
        default: ;
      endcase
      due.push_back(r);
    endfunction

    function void take_result(res_word_t got);
      res_word_t want;
      if (due.size() == 0) begin
        complain($sformatf("result word byte %02h status %0d arrived unasked",
                           got.read_byte, got.status));
        return;
      end
      want = due.pop_front();
      if (got.read_byte !== want.read_byte || got.status !== want.status)
        complain($sformatf("expected byte %02h status %0d, got byte %02h status %0d",
                           want.read_byte, want.status, got.read_byte, got.status));
    endfunction

    function int pending();
      return due.size();
    endfunction

    function void flush_leftovers();
      while (due.size() != 0) begin
        void'(due.pop_front());
        complain("result word never arrived");
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_word_t cmd = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_word_t res;

  int gap_pct = 0;
  int stall_pct = 0;
  int phase_gap [4] = '{0, 71, 0, 7};
  int phase_stall [4] = '{0, 0, 71, 7};
  frame_mirror mirror;

  page_framebuffer_box_and_pixel_engine dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) mirror.take_result(res);
    res_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  function automatic cmd_word_t make_cmd(logic [2:0] kind, int x, int y, int pg, int bw,
                                         int bh, int cut, logic mode);
    cmd_word_t w;
    w.kind = kind;
    w.x_pos = 8'(x);
    w.y_pos = 7'(y);
    w.page_index = 3'(pg);
    w.box_width = 8'(bw);
    w.box_height = 7'(bh);
    w.corner_cut = 6'(cut);
    w.fill_mode = mode;
    return w;
  endfunction

  function automatic cmd_word_t random_command();
    cmd_word_t w;
    logic [63:0] noise;
    int roll, bw, bh, narrow;
    noise = {$urandom, $urandom};
    w = noise[$bits(cmd_word_t)-1:0];
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      w.kind = 3'($urandom_range(KIND_SET, KIND_CLEAR));
      if ($urandom_range(0, 9) != 0) begin
        w.x_pos = 8'($urandom_range(0, COLUMNS - 1));
        w.y_pos = 7'($urandom_range(0, ROWS - 1));
      end
    end else if (roll < 72) begin
      w.kind = KIND_BOX;
      if ($urandom_range(0, 9) != 0) begin
        if ($urandom_range(0, 9) == 0) begin
          bw = $urandom_range(0, COLUMNS);
          bh = $urandom_range(0, ROWS);
        end else begin
          bw = $urandom_range(0, 20);
          bh = $urandom_range(0, 20);
        end
        narrow = (bw < bh) ? bw : bh;
        w.box_width = 8'(bw);
        w.box_height = 7'(bh);
        w.corner_cut = 6'($urandom_range(0, narrow / 2));
        w.x_pos = 8'($urandom_range(1, COLUMNS - bw + 1));
        w.y_pos = 7'($urandom_range(bh, ROWS));
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 4))
            0: w.x_pos = 8'd0;
            1: w.x_pos = 8'(COLUMNS - bw + 2);
            2: w.y_pos = 7'(bh - 1);
            3: w.y_pos = 7'(ROWS + 1);
            default: w.corner_cut = 6'(narrow / 2 + 1);
          endcase
        end
      end
    end else if (roll < 95) begin
      w.kind = KIND_READ;
      if ($urandom_range(0, 9) != 0) w.x_pos = 8'($urandom_range(0, COLUMNS - 1));
    end else begin
      w.kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
    end
    return w;
  endfunction

  task automatic send_command(input cmd_word_t w);
    while ($urandom_range(0, 99) < gap_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= w;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    mirror.take_command(w);
  endtask

  task automatic run_directed();
    send_command(make_cmd(KIND_READ, 0, 0, 0, 0, 0, 0, FILL_SET));
    send_command(make_cmd(KIND_SET, 0, 0, 0, 0, 0, 0, FILL_SET));
    send_command(make_cmd(KIND_SET, COLUMNS - 1, ROWS - 1, 0, 0, 0, 0, FILL_SET));
    send_command(make_cmd(KIND_INVERT, COLUMNS - 1, ROWS - 2, 0, 0, 0, 0, FILL_SET));
    send_command(make_cmd(KIND_CLEAR, 0, 0, 0, 0, 0, 0, FILL_SET));
    send_command(make_cmd(KIND_SET, COLUMNS, 0, 0, 0, 0, 0, FILL_SET));
    send_command(make_cmd(KIND_INVERT, 255, 127, 7, 255, 127, 63, FILL_INVERT));
    send_command(make_cmd(KIND_CLEAR, 3, ROWS, 0, 0, 0, 0, FILL_SET));
    send_command(make_cmd(KIND_READ, COLUMNS - 1, 0, PAGES - 1, 0, 0, 0, FILL_SET));
    send_command(make_cmd(KIND_READ, COLUMNS, 0, 0, 0, 0, 0, FILL_SET));
    send_command(make_cmd(KIND_BOX, 1, ROWS, 0, COLUMNS, ROWS, 0, FILL_SET));
    send_command(make_cmd(KIND_READ, 64, 0, 3, 0, 0, 0, FILL_SET));
    send_command(make_cmd(KIND_BOX, 1, ROWS, 0, COLUMNS, ROWS, ROWS / 2, FILL_INVERT));
    send_command(make_cmd(KIND_READ, 0, 0, 0, 0, 0, 0, FILL_SET));
    send_command(make_cmd(KIND_READ, 63, 0, 4, 0, 0, 0, FILL_SET));
    send_command(make_cmd(KIND_BOX, 0, 10, 0, 4, 4, 0, FILL_SET));
    send_command(make_cmd(KIND_BOX, 2, 1, 0, COLUMNS, 1, 0, FILL_SET));
    send_command(make_cmd(KIND_BOX, 1, ROWS + 1, 0, 1, 1, 0, FILL_SET));
    send_command(make_cmd(KIND_BOX, 5, 10, 0, 4, 11, 0, FILL_SET));
    send_command(make_cmd(KIND_BOX, 5, 20, 0, 5, 10, 3, FILL_SET));
    send_command(make_cmd(KIND_BOX, 5, 20, 0, 10, 5, 3, FILL_INVERT));
    send_command(make_cmd(KIND_BOX, 1, 5, 0, 0, 5, 0, FILL_SET));
    send_command(make_cmd(KIND_BOX, COLUMNS - 9, 0, 0, 10, 0, 0, FILL_INVERT));
    send_command(make_cmd(KIND_SPARE_LO, 7, 7, 1, 1, 1, 0, FILL_SET));
    send_command(make_cmd(KIND_SPARE_HI, 255, 127, 7, 255, 127, 63, FILL_INVERT));
  endtask

  initial begin
    int spins;
    mirror = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    for (int p = 0; p < 4; p++) begin
      gap_pct = phase_gap[p];
      stall_pct = phase_stall[p];
      for (int i = 0; i < RANDOM_WORDS / 4; i++) send_command(random_command());
    end
    cmd_valid <= 1'b0;
    spins = 0;
    while (mirror.pending() != 0 && spins < 100000) begin
      @(posedge clk);
      spins++;
    end
    repeat (16) @(posedge clk);
    mirror.flush_leftovers();
    $display("summary: %0d pixel, %0d box (%0d refused) and %0d read words checked",
             mirror.pixel_cmds, mirror.box_cmds, mirror.box_refused, mirror.read_cmds);
    $display("summary: %0d reads returned set pixels, %0d failures in all",
             mirror.read_lit, mirror.errors);
    if (mirror.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #200000000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
